@@ hdl/ocf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the occupancy cell fusion block.
// No dependencies; imported by ocf_merge, occupancy_cell_fusion and the testbench.

package ocf_pkg;

    // Field widths
    localparam int CellW  = 8;
    localparam int ThrW   = 7;
    localparam int IndexW = 20;

    // Grid size limit for the position counter
    localparam longint MaxCells = 1048576;

    // Configuration register indexes
    localparam logic [0:0] RegFreeThr = 1'b0;
    localparam logic [0:0] RegOccThr  = 1'b1;

    // Reset values of the thresholds
    localparam logic [ThrW-1:0] FreeThrReset = 7'd25;
    localparam logic [ThrW-1:0] OccThrReset  = 7'd65;

    // Occupancy midpoint and the value for a cell nobody knows
    localparam logic signed [CellW:0]   Midpoint   = 9'sd50;
    localparam logic signed [CellW-1:0] UnknownOut = -8'sd1;

    // Flags that go along with each merged cell
    typedef struct packed {
        logic contradiction;
        logic new_for_second;
        logic new_for_first;
    } ocf_flags_t;

endpackage

@@ hdl/ocf_merge.sv @@
`timescale 1ns / 1ps
// Combinational merge of one cell pair: known checks, threshold classes,
// conflict flag and the pick of the reading farther from the midpoint.
// Depends on ocf_pkg.

module ocf_merge
    import ocf_pkg::*;
(
    input  logic signed [CellW-1:0] cell_first,
    input  logic signed [CellW-1:0] cell_second,
    input  logic [ThrW-1:0]         free_threshold,
    input  logic [ThrW-1:0]         occupied_threshold,
    output logic signed [CellW-1:0] merged_cell,
    output ocf_flags_t              flags
);

    logic known_a;
    logic known_b;
    logic free_a;
    logic free_b;
    logic occ_a;
    logic occ_b;
    logic signed [CellW:0] diff_a;
    logic signed [CellW:0] diff_b;
    logic [CellW-1:0] dist_a;
    logic [CellW-1:0] dist_b;

    // Negative means unknown
    assign known_a = ~cell_first[CellW-1];
    assign known_b = ~cell_second[CellW-1];

    // Classes; only used when the cell is known, so the low 7 bits hold the value
    assign free_a = (cell_first[ThrW-1:0]  < free_threshold);
    assign free_b = (cell_second[ThrW-1:0] < free_threshold);
    assign occ_a  = ~free_a & (cell_first[ThrW-1:0]  > occupied_threshold);
    assign occ_b  = ~free_b & (cell_second[ThrW-1:0] > occupied_threshold);

    // Distance from the midpoint
    assign diff_a = {1'b0, cell_first[ThrW-1:0]}  - Midpoint;
    assign diff_b = {1'b0, cell_second[ThrW-1:0]} - Midpoint;
    assign dist_a = diff_a[CellW] ? CellW'(-diff_a) : diff_a[CellW-1:0];
    assign dist_b = diff_b[CellW] ? CellW'(-diff_b) : diff_b[CellW-1:0];

    // Merge selection
    always_comb
    begin
        flags = '0;
        case ({known_a, known_b})
            2'b00:
            begin
                merged_cell = UnknownOut;
            end
            2'b10:
            begin
                merged_cell          = cell_first;
                flags.new_for_second = 1'b1;
            end
            2'b01:
            begin
                merged_cell         = cell_second;
                flags.new_for_first = 1'b1;
            end
            default:
            begin
                flags.contradiction = (free_a & occ_b) | (occ_a & free_b);
                // tie goes to the first grid
                merged_cell = (dist_b > dist_a) ? cell_second : cell_first;
            end
        endcase
    end

endmodule

@@ hdl/occupancy_cell_fusion.sv @@
`timescale 1ns / 1ps
// Top level of the occupancy cell fusion block: stream ports, threshold
// registers, cell position counter and the two-stage pipeline.
// Depends on ocf_pkg and ocf_merge.
//
//  Channel | Signals                          | Content
//  --------+----------------------------------+-------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tlast| cell pair in, tlast = final_cell
//  m_      | m_tvalid m_tready m_tdata m_tuser| merged cell, index, flags,
//          | m_tlast                          | tlast = grid_done
//  cfg_    | cfg_wr_en cfg_addr cfg_wdata     | threshold writes, no read-back
//
// One cell pair per cycle sustained while the output is ready; a pair goes
// through the input register, then the result register, which offers it.
// Reset clears the pipeline valids, the position counter and sets the
// thresholds to 25 and 65.
// A stalled output holds the result register; the input register still takes
// a new pair when it or the result register is empty, or m_tready is high.

module occupancy_cell_fusion
    import ocf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // configuration
    input  logic            cfg_wr_en,
    input  logic [0:0]      cfg_addr,
    input  logic [ThrW-1:0] cfg_wdata,
    // input stream
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,   // [7:0] cell_first, [15:8] cell_second
    input  logic            s_tlast,   // final_cell
    // output stream
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,   // [7:0] merged_cell, [27:8] cell_index, rest 0
    output logic [2:0]      m_tuser,   // [0] new_for_first, [1] new_for_second,
                                       // [2] contradiction
    output logic            m_tlast    // grid_done
);

    logic [ThrW-1:0]   free_thr_reg;
    logic [ThrW-1:0]   occ_thr_reg;
    logic [IndexW-1:0] pos_reg;
    logic [IndexW-1:0] pos_next;
    logic [IndexW:0]   pos_inc;

    logic                     s1_valid_reg;
    logic signed [CellW-1:0]  s1_first_reg;
    logic signed [CellW-1:0]  s1_second_reg;
    logic                     s1_last_reg;
    logic [IndexW-1:0]        s1_index_reg;

    logic                     s2_valid_reg;
    logic signed [CellW-1:0]  s2_merged_reg;
    logic [IndexW-1:0]        s2_index_reg;
    ocf_flags_t               s2_flags_reg;
    logic                     s2_last_reg;

    logic                     in_xfer;
    logic                     s1_advance;
    logic signed [CellW-1:0]  merged_cell;
    ocf_flags_t               flags;

    // Handshake control
    assign s1_advance = s1_valid_reg & (~s2_valid_reg | m_tready);
    assign s_tready   = ~s1_valid_reg | ~s2_valid_reg | m_tready;
    assign in_xfer    = s_tvalid & s_tready;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_thr_reg <= FreeThrReset;
            occ_thr_reg  <= OccThrReset;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                RegFreeThr: free_thr_reg <= cfg_wdata;
                RegOccThr:  occ_thr_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Position counter, restarts after the final cell or the grid size limit
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign pos_next = (s_tlast || (longint'(pos_inc) >= MaxCells)) ? '0
                                                                   : pos_inc[IndexW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (in_xfer)
            pos_reg <= pos_next;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_first_reg  <= s_tdata[7:0];
            s1_second_reg <= s_tdata[15:8];
            s1_last_reg   <= s_tlast;
            s1_index_reg  <= pos_reg;
        end
    end

    ocf_merge u_merge (
        .cell_first         (s1_first_reg),
        .cell_second        (s1_second_reg),
        .free_threshold     (free_thr_reg),
        .occupied_threshold (occ_thr_reg),
        .merged_cell        (merged_cell),
        .flags              (flags)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (~s2_valid_reg | m_tready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            s2_merged_reg <= merged_cell;
            s2_index_reg  <= s1_index_reg;
            s2_flags_reg  <= flags;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Output ports
    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {4'b0, s2_index_reg, s2_merged_reg};
    assign m_tuser  = s2_flags_reg;
    assign m_tlast  = s2_last_reg;

    // Checks
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the output drains");

    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> (pos_reg == '0))
        else $error("position counter did not restart after the final cell");

    a_new_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({s2_flags_reg.new_for_first, s2_flags_reg.new_for_second,
                               s2_flags_reg.contradiction}))
        else $error("more than one result flag set");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("input register lost an item while the output stalled");

endmodule

@@ sim/occupancy_cell_fusion_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for occupancy_cell_fusion: drives cell pairs with
// random bursts and output stalls, and predicts every merged cell in a scoreboard.
// Depends on ocf_pkg and the occupancy_cell_fusion RTL.

module occupancy_cell_fusion_tb;
    import ocf_pkg::*;

    localparam int CycleLimit = 100000;
    localparam int PhaseItems = 55;

    // One predicted output transfer
    typedef struct packed {
        logic [CellW-1:0]  merged;
        logic [IndexW-1:0] index;
        ocf_flags_t        flags;
        logic              done;
    } fused_cell_t;

    typedef enum {KindUndecided, KindFree, KindOccupied} cell_kind_t;

    // Scoreboard: holds its own threshold and position state, predicts
    // each accepted pair and checks results in order
    class cell_fusion_scoreboard;
        logic [ThrW-1:0]   free_thr;
        logic [ThrW-1:0]   occ_thr;
        logic [IndexW-1:0] next_index;
        fused_cell_t       awaited[$];
        int mismatches;
        int pairs;
        int both_unknown;
        int one_sided;
        int conflicts;
        int grids;

        function new();
            free_thr     = FreeThrReset;
            occ_thr      = OccThrReset;
            next_index   = '0;
            mismatches   = 0;
            pairs        = 0;
            both_unknown = 0;
            one_sided    = 0;
            conflicts    = 0;
            grids        = 0;
        endfunction

        function void set_reg(logic [0:0] addr, logic [ThrW-1:0] val);
            if (addr == RegFreeThr)
                free_thr = val;
            else if (addr == RegOccThr)
                occ_thr = val;
        endfunction

        // Free wins over occupied when the thresholds overlap
        function cell_kind_t kind_of(int v);
            if (v < int'(free_thr))
                return KindFree;
            if (v > int'(occ_thr))
                return KindOccupied;
            return KindUndecided;
        endfunction

        function int dist_from_mid(int v);
            int d;
            d = v - int'(Midpoint);
            return (d < 0) ? -d : d;
        endfunction

        function void note_pair(logic [CellW-1:0] first, logic [CellW-1:0] second,
                                logic last);
            fused_cell_t e;
            int          va;
            int          vb;
            cell_kind_t  ka;
            cell_kind_t  kb;
            va      = int'($signed(first));
            vb      = int'($signed(second));
            e.index = next_index;
            e.done  = last;
            e.flags = '0;
            if (va < 0 && vb < 0) begin
                e.merged = UnknownOut;
                both_unknown++;
            end else if (vb < 0) begin
                e.merged = first;
                e.flags.new_for_second = 1'b1;
                one_sided++;
            end else if (va < 0) begin
                e.merged = second;
                e.flags.new_for_first = 1'b1;
                one_sided++;
            end else begin
                ka = kind_of(va);
                kb = kind_of(vb);
                if ((ka == KindFree && kb == KindOccupied) ||
                    (ka == KindOccupied && kb == KindFree)) begin
                    e.flags.contradiction = 1'b1;
                    conflicts++;
                end
                // tie goes to the first grid
                e.merged = (dist_from_mid(vb) > dist_from_mid(va)) ? second : first;
            end
            awaited.insert(awaited.size(), e);
            pairs++;
            if (last)
                grids++;
            if (last || longint'(next_index) + 1 >= MaxCells)
                next_index = '0;
            else
                next_index = next_index + 1'b1;
        endfunction

        function void check_result(logic [31:0] tdata, logic [2:0] tuser, logic tlast);
            fused_cell_t e;
            if (awaited.size() == 0) begin
                $error("unexpected result: merged_cell %0d cell_index %0d",
                       $signed(tdata[7:0]), tdata[27:8]);
                mismatches++;
                return;
            end
            e = awaited.pop_front();
            if (tdata[7:0] !== e.merged) begin
                $error("merged_cell: expected %0d, got %0d",
                       $signed(e.merged), $signed(tdata[7:0]));
                mismatches++;
            end
            if (tdata[27:8] !== e.index) begin
                $error("cell_index: expected %0d, got %0d", e.index, tdata[27:8]);
                mismatches++;
            end
            if (tdata[31:28] !== 4'b0) begin
                $error("tdata padding: expected 0, got %0h", tdata[31:28]);
                mismatches++;
            end
            if (tuser[0] !== e.flags.new_for_first) begin
                $error("new_for_first: expected %0b, got %0b",
                       e.flags.new_for_first, tuser[0]);
                mismatches++;
            end
            if (tuser[1] !== e.flags.new_for_second) begin
                $error("new_for_second: expected %0b, got %0b",
                       e.flags.new_for_second, tuser[1]);
                mismatches++;
            end
            if (tuser[2] !== e.flags.contradiction) begin
                $error("contradiction: expected %0b, got %0b",
                       e.flags.contradiction, tuser[2]);
                mismatches++;
            end
            if (tlast !== e.done) begin
                $error("grid_done: expected %0b, got %0b", e.done, tlast);
                mismatches++;
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [0:0]      cfg_addr;
    logic [ThrW-1:0] cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [15:0]     s_tdata;   // [7:0] cell_first, [15:8] cell_second
    logic            s_tlast;   // final_cell
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [31:0]     m_tdata;   // [7:0] merged_cell, [27:8] cell_index, rest 0
    logic [2:0]      m_tuser;   // [0] new_for_first, [1] new_for_second,
                                // [2] contradiction
    logic            m_tlast;   // grid_done

    cell_fusion_scoreboard sb;
    int cycles   = 0;
    int rx_mode  = 0;
    int rx_run   = 0;
    bit rx_hold  = 1'b0;
    int settings = 1;

    occupancy_cell_fusion uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver stall pattern: always ready, coin toss, or runs of stalls
    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_hold = !rx_hold;
            rx_run  = rx_hold ? $urandom_range(1, 12) : $urandom_range(1, 20);
        end
        rx_run--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= !rx_hold;
        endcase
    end

    // Output transfers are checked at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("[occupancy_cell_fusion] ERROR");
            $finish;
        end
    end

    // Mostly readings 0..100, some unknowns, some above 100, some at or next to the thresholds
    function automatic logic [CellW-1:0] rand_cell();
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = -int'($urandom_range(1, 128));
            7:       v = $urandom_range(101, 127);
            8:       v = int'(sb.free_thr) + int'($urandom_range(0, 2)) - 1;
            9:       v = int'(sb.occ_thr) + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, 100);
        endcase
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[CellW-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic push_cell(logic [CellW-1:0] first, logic [CellW-1:0] second,
                             logic last);
        s_tdata  <= {second, first};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pair(first, second, last);
        @(negedge clk);
    endtask

    task automatic idle_inputs();
        s_tvalid <= 1'b0;
        s_tdata  <= 16'($urandom);
        s_tlast  <= 1'($urandom_range(0, 1));
    endtask

    task automatic wait_drained();
        while (sb.awaited.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Only with the pipeline empty; it waits for the drain, then idles so the two stages are clear
    task automatic write_thresholds(logic [ThrW-1:0] free_val, logic [ThrW-1:0] occ_val);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= RegFreeThr;
        cfg_wdata <= free_val;
        @(negedge clk);
        cfg_addr  <= RegOccThr;
        cfg_wdata <= occ_val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wdata <= ThrW'($urandom);
        sb.set_reg(RegFreeThr, free_val);
        sb.set_reg(RegOccThr, occ_val);
        settings++;
    endtask

    // Random grids; bursts with gaps when asked, one full drain at hold_at
    task automatic run_phase(int count, bit gaps, int last_odds, int hold_at);
        int burst;
        int i;
        burst = $urandom_range(1, 16);
        for (i = 0; i < count; i++)
        begin
            push_cell(rand_cell(), rand_cell(), $urandom_range(1, last_odds) == 1);
            if (i == hold_at)
            begin
                idle_inputs();
                wait_drained();
            end
            else if (gaps)
            begin
                burst--;
                if (burst == 0)
                begin
                    idle_inputs();
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    burst = $urandom_range(1, 16);
                end
            end
        end
        idle_inputs();
    endtask

    initial
    begin : main
        int              phase;
        logic [ThrW-1:0] fthr;
        logic [ThrW-1:0] othr;
        sb        = new();
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = RegFreeThr;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pairs at reset thresholds (free below 25, occupied above 65)
        push_cell(8'h80, 8'h80, 1'b0);   // both unknown, most negative
        push_cell(8'hFF, 8'hFF, 1'b0);   // both unknown, -1
        push_cell(8'd0, 8'hFF, 1'b0);    // only first known
        push_cell(8'h80, 8'd127, 1'b0);  // only second known
        push_cell(8'd127, 8'hFB, 1'b0);
        push_cell(8'd10, 8'd90, 1'b0);   // conflict, equal distance: first wins
        push_cell(8'd90, 8'd10, 1'b0);
        push_cell(8'd40, 8'd60, 1'b0);   // tie, both undecided
        push_cell(8'd24, 8'd66, 1'b0);   // just past both thresholds
        push_cell(8'd25, 8'd65, 1'b0);   // exactly on the thresholds
        push_cell(8'd120, 8'd5, 1'b0);   // reading above 100
        push_cell(8'd101, 8'd100, 1'b0);
        push_cell(8'd0, 8'd0, 1'b0);
        push_cell(8'd127, 8'd127, 1'b1); // end of grid
        push_cell(8'd50, 8'd49, 1'b0);
        push_cell(8'd55, 8'd45, 1'b1);
        push_cell(8'd30, 8'd127, 1'b1);  // grid of one cell
        push_cell(8'hB3, 8'd63, 1'b0);
        idle_inputs();

        // Threshold settings: extremes, overlap, reset values, then random
        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:       begin fthr = 7'd0;   othr = 7'd0;   end
                1:       begin fthr = 7'd100; othr = 7'd100; end
                2:       begin fthr = 7'd100; othr = 7'd20;  end
                3:       begin fthr = 7'd0;   othr = 7'd127; end
                4:       begin fthr = 7'd127; othr = 7'd0;   end
                5:       begin fthr = FreeThrReset; othr = OccThrReset; end
                default:
                begin
                    fthr = ThrW'($urandom_range(0, 100));
                    othr = ThrW'($urandom_range(0, 100));
                end
            endcase
            write_thresholds(fthr, othr);
            rx_mode <= phase % 3;
            run_phase(PhaseItems, phase % 3 != 0, (phase == 7) ? 1000 : 12,
                      (phase == 4) ? 27 : -1);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d cell pairs over %0d threshold settings, %0d grids closed.",
                 sb.pairs, settings, sb.grids);
        $display("Cases seen: %0d both unknown, %0d one-sided, %0d contradictions; %0d mismatches.",
                 sb.both_unknown, sb.one_sided, sb.conflicts, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("[occupancy_cell_fusion] OK");
        else
            $display("[occupancy_cell_fusion] ERROR");
        $finish;
    end

endmodule
